/* design/address_keyed_hash_table_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the address keyed hash table
// Shared property wrappers used by the checker.
// ---------------------------------------------------------------------------
`ifndef ADDRESS_KEYED_HASH_TABLE_TOP_DEFINES_SVH
`define ADDRESS_KEYED_HASH_TABLE_TOP_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define AHKT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds across reset.
`define AHKT_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ahkt_pkg.sv */
// ---------------------------------------------------------------------------
// ahkt_pkg
// Types, constants and helpers for the address keyed hash table.
// ---------------------------------------------------------------------------
`default_nettype none

package ahkt_pkg;

    localparam int SLOT_INDEX_BITS = 16;
    localparam int MAX_ENTRIES     = 512;

    localparam int SLOT_COUNT    = 1 << SLOT_INDEX_BITS;
    localparam int ENTRY_BITS    = $clog2(MAX_ENTRIES);
    localparam int COUNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int PROBE_STRIDE  = 17;
    localparam int DATA_BITS     = 64;
    localparam int OUT_IDX_BITS  = 9;
    localparam int STATUS_BITS   = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_ENT_CHK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                  valid;
        logic [ENTRY_BITS-1:0] idx;
    } t_slot;

    // controller -> datapath
    typedef struct packed {
        logic    clr_wr;      // clear one slot and advance the sweep
        logic    load_req;    // capture the accepted beat
        logic    probe_adv;   // step to the next slot in the chain
        logic    commit;      // write the entry and claim the current slot
        logic    res_load;    // capture the result
        t_status res_status;
        logic    out_load;    // move the result to the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic is_insert;
        logic store_full;
        logic slot_valid;
        logic addr_match;
        logic probe_last;
        logic out_busy;
    } t_dp_sts;

    function automatic logic [OUT_IDX_BITS-1:0] to_out_idx(input logic [ENTRY_BITS-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[OUT_IDX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/ahkt_if.sv */
// ---------------------------------------------------------------------------
// ahkt_if
// Request and response channels of the address keyed hash table.
// ---------------------------------------------------------------------------
`default_nettype none

interface ahkt_req_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [ahkt_pkg::DATA_BITS-1:0]  address;
    logic [ahkt_pkg::DATA_BITS-1:0]  symbol_length;

    modport source (output valid, op, address, symbol_length, input ready);
    modport sink   (input valid, op, address, symbol_length, output ready);
endinterface

interface ahkt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ahkt_pkg::STATUS_BITS-1:0]   status;
    logic [ahkt_pkg::OUT_IDX_BITS-1:0]  entry_index;
    logic [ahkt_pkg::DATA_BITS-1:0]     found_length;

    modport source (output valid, status, entry_index, found_length, input ready);
    modport sink   (input valid, status, entry_index, found_length, output ready);
endinterface

`default_nettype wire

/* design/address_keyed_hash_table_top.sv */
// Steps: an insert does a slot read and a check for each slot it probes, a refused
// insert (store full) ends after its slot read; a lookup does a slot read, a check
// and an entry read per occupied slot and ends on a match or on an empty slot.
// Throughput: one item at a time; the next beat is taken the cycle after the
// result is moved to the output register, which may still be waiting on its sink.
// Reset: synchronous; then a sweep empties all 65536 slots, ready held low.
// ---------------------------------------------------------------------------
// address_keyed_hash_table_top
// Open addressed hash table of symbol addresses with linear probing.
// ---------------------------------------------------------------------------
`default_nettype none

module address_keyed_hash_table_top (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ahkt_req_if.sink      i_req,
    ahkt_rsp_if.source    o_rsp
);

    ahkt_pkg::t_dp_cmd  dp_cmd;
    ahkt_pkg::t_dp_sts  dp_sts;
    ahkt_pkg::t_status  rsp_status;
    logic               req_ready;

    ahkt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (dp_sts),
        .o_req_ready (req_ready),
        .o_cmd       (dp_cmd)
    );

    ahkt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (i_req.op),
        .i_address       (i_req.address),
        .i_symbol_length (i_req.symbol_length),
        .i_rsp_ready     (o_rsp.ready),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .o_rsp_valid     (o_rsp.valid),
        .o_status        (rsp_status),
        .o_entry_index   (o_rsp.entry_index),
        .o_found_length  (o_rsp.found_length)
    );

    assign i_req.ready  = req_ready;
    assign o_rsp.status = rsp_status;

endmodule

`default_nettype wire

/* design/ahkt_dp.sv */
// ---------------------------------------------------------------------------
// ahkt_dp
// Datapath: slot table, entry store, probe position, result and output regs.
// ---------------------------------------------------------------------------
`default_nettype none

module ahkt_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_op,
    input  wire logic [ahkt_pkg::DATA_BITS-1:0]       i_address,
    input  wire logic [ahkt_pkg::DATA_BITS-1:0]       i_symbol_length,
    input  wire logic                                 i_rsp_ready,
    input  wire ahkt_pkg::t_dp_cmd                    i_cmd,
    output ahkt_pkg::t_dp_sts                         o_sts,
    output logic                                      o_rsp_valid,
    output ahkt_pkg::t_status                         o_status,
    output logic [ahkt_pkg::OUT_IDX_BITS-1:0]         o_entry_index,
    output logic [ahkt_pkg::DATA_BITS-1:0]            o_found_length
);

    // storage
    ahkt_pkg::t_slot                        r_slot_mem     [ahkt_pkg::SLOT_COUNT];
    logic [ahkt_pkg::DATA_BITS-1:0]         r_ent_addr_mem [ahkt_pkg::MAX_ENTRIES];
    logic [ahkt_pkg::DATA_BITS-1:0]         r_ent_len_mem  [ahkt_pkg::MAX_ENTRIES];

    ahkt_pkg::t_slot                        r_slot_q;
    logic [ahkt_pkg::DATA_BITS-1:0]         r_ent_addr_q;
    logic [ahkt_pkg::DATA_BITS-1:0]         r_ent_len_q;

    // control state
    logic [ahkt_pkg::SLOT_INDEX_BITS-1:0]   r_clr_addr;
    logic [ahkt_pkg::COUNT_BITS-1:0]        r_count;
    logic                                   r_out_valid;

    // item payload
    ahkt_pkg::t_op                          r_op;
    logic [ahkt_pkg::DATA_BITS-1:0]         r_key;
    logic [ahkt_pkg::DATA_BITS-1:0]         r_len;
    logic [ahkt_pkg::SLOT_INDEX_BITS-1:0]   r_pos;
    logic [ahkt_pkg::SLOT_INDEX_BITS-1:0]   r_probe;

    // result and output
    ahkt_pkg::t_status                      r_res_status;
    logic [ahkt_pkg::ENTRY_BITS-1:0]        r_res_idx;
    logic [ahkt_pkg::DATA_BITS-1:0]         r_res_len;
    ahkt_pkg::t_status                      r_out_status;
    logic [ahkt_pkg::OUT_IDX_BITS-1:0]      r_out_idx;
    logic [ahkt_pkg::DATA_BITS-1:0]         r_out_len;

    logic [ahkt_pkg::ENTRY_BITS-1:0]        wr_idx;

    assign wr_idx = r_count[ahkt_pkg::ENTRY_BITS-1:0];

    // slot table: one write port shared by the clear sweep and inserts
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_slot_mem[r_clr_addr] <= '0;
        end else if (i_cmd.commit) begin
            r_slot_mem[r_pos] <= '{valid: 1'b1, idx: wr_idx};
        end
        r_slot_q <= r_slot_mem[r_pos];
    end

    // entry store: read follows the slot just fetched
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ent_addr_mem[wr_idx] <= r_key;
            r_ent_len_mem[wr_idx]  <= r_len;
        end
        r_ent_addr_q <= r_ent_addr_mem[r_slot_q.idx];
        r_ent_len_q  <= r_ent_len_mem[r_slot_q.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.commit) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op    <= ahkt_pkg::t_op'(i_op);
            r_key   <= i_address;
            r_len   <= i_symbol_length;
            r_pos   <= i_address[ahkt_pkg::SLOT_INDEX_BITS-1:0];
            r_probe <= '0;
        end else if (i_cmd.probe_adv) begin
            r_pos   <= r_pos + ahkt_pkg::SLOT_INDEX_BITS'(ahkt_pkg::PROBE_STRIDE);
            r_probe <= r_probe + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            if (i_cmd.res_status != ahkt_pkg::ST_OK) begin
                r_res_idx <= '0;
                r_res_len <= '0;
            end else if (r_op == ahkt_pkg::OP_INSERT) begin
                r_res_idx <= wr_idx;
                r_res_len <= '0;
            end else begin
                r_res_idx <= r_slot_q.idx;
                r_res_len <= r_ent_len_q;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= ahkt_pkg::to_out_idx(r_res_idx);
            r_out_len    <= r_res_len;
        end
    end

    always_comb begin
        o_sts.clr_done   = &r_clr_addr;
        o_sts.is_insert  = (r_op == ahkt_pkg::OP_INSERT);
        o_sts.store_full = (r_count >= ahkt_pkg::COUNT_BITS'(ahkt_pkg::MAX_ENTRIES));
        o_sts.slot_valid = r_slot_q.valid;
        o_sts.addr_match = (r_ent_addr_q == r_key);
        o_sts.probe_last = &r_probe;
        o_sts.out_busy   = r_out_valid && !i_rsp_ready;
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_entry_index  = r_out_idx;
    assign o_found_length = r_out_len;

endmodule

`default_nettype wire

/* design/ahkt_ctrl.sv */
// ---------------------------------------------------------------------------
// ahkt_ctrl
// Controller: clear sweep, probe sequencing and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module ahkt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    input  wire ahkt_pkg::t_dp_sts   i_sts,
    output logic                     o_req_ready,
    output ahkt_pkg::t_dp_cmd        o_cmd
);

    ahkt_pkg::t_state r_state;
    ahkt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ahkt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ahkt_pkg::S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = ahkt_pkg::S_IDLE;
                end
            end
            ahkt_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = ahkt_pkg::S_SLOT_RD;
                end
            end
            ahkt_pkg::S_SLOT_RD: begin
                if (i_sts.is_insert && i_sts.store_full) begin
                    n_state = ahkt_pkg::S_FINISH;
                end else begin
                    n_state = ahkt_pkg::S_SLOT_CHK;
                end
            end
            ahkt_pkg::S_SLOT_CHK: begin
                if (!i_sts.slot_valid) begin
                    n_state = ahkt_pkg::S_FINISH;
                end else if (!i_sts.is_insert) begin
                    n_state = ahkt_pkg::S_ENT_CHK;
                end else if (i_sts.probe_last) begin
                    n_state = ahkt_pkg::S_FINISH;
                end else begin
                    n_state = ahkt_pkg::S_SLOT_RD;
                end
            end
            ahkt_pkg::S_ENT_CHK: begin
                if (i_sts.addr_match || i_sts.probe_last) begin
                    n_state = ahkt_pkg::S_FINISH;
                end else begin
                    n_state = ahkt_pkg::S_SLOT_RD;
                end
            end
            ahkt_pkg::S_FINISH: begin
                if (!i_sts.out_busy) begin
                    n_state = ahkt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ahkt_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ahkt_pkg::ST_OK;
        o_req_ready      = 1'b0;
        case (r_state)
            ahkt_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            ahkt_pkg::S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.load_req = i_req_valid;
            end
            ahkt_pkg::S_SLOT_RD: begin
                if (i_sts.is_insert && i_sts.store_full) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ahkt_pkg::ST_FULL;
                end
            end
            ahkt_pkg::S_SLOT_CHK: begin
                if (!i_sts.slot_valid) begin
                    // empty slot ends the chain either way
                    o_cmd.res_load   = 1'b1;
                    o_cmd.commit     = i_sts.is_insert;
                    o_cmd.res_status = i_sts.is_insert ? ahkt_pkg::ST_OK
                                                       : ahkt_pkg::ST_NOT_FOUND;
                end else if (i_sts.is_insert) begin
                    if (i_sts.probe_last) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ahkt_pkg::ST_FULL;
                    end else begin
                        o_cmd.probe_adv = 1'b1;
                    end
                end
            end
            ahkt_pkg::S_ENT_CHK: begin
                if (i_sts.addr_match) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ahkt_pkg::ST_OK;
                end else if (i_sts.probe_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ahkt_pkg::ST_NOT_FOUND;
                end else begin
                    o_cmd.probe_adv = 1'b1;
                end
            end
            ahkt_pkg::S_FINISH: begin
                o_cmd.out_load = !i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/ahkt_checker.sv */
// ---------------------------------------------------------------------------
// ahkt_checker
// Port-level checks for the address keyed hash table, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
`include "address_keyed_hash_table_top_defines.svh"

module ahkt_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_req_valid,
    input  wire logic                                 i_req_ready,
    input  wire logic                                 i_rsp_valid,
    input  wire logic                                 i_rsp_ready,
    input  wire logic [ahkt_pkg::STATUS_BITS-1:0]     i_rsp_status,
    input  wire logic [ahkt_pkg::OUT_IDX_BITS-1:0]    i_rsp_entry_index,
    input  wire logic [ahkt_pkg::DATA_BITS-1:0]       i_rsp_found_length
);

    `AHKT_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "response beat dropped while stalled")

    `AHKT_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready |=> !i_req_ready, "request taken while an item is in work")

    `AHKT_ASSERT(a_fail_zero, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status != ahkt_pkg::ST_OK) |-> (i_rsp_entry_index == '0) && (i_rsp_found_length == '0), "failed response carries nonzero fields")

    `AHKT_ASSERT_NORST(a_reset_quiet, i_clk, !i_rst_n |=> !i_rsp_valid && !i_req_ready, "channels active after reset")

endmodule

bind address_keyed_hash_table_top ahkt_checker u_ahkt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_entry_index  (o_rsp.entry_index),
    .i_rsp_found_length (o_rsp.found_length)
);

`default_nettype wire
